### hw/rtl/dqcr_pkg.sv
// shared types, constants and the edge counting function of the dual quadrature counter readout
package dqcr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one read transaction: the snapshot taken at the previous read
  typedef struct packed {
    logic signed [7:0] held_two;
    logic signed [7:0] held_one;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    PHASE_FIRST  = 1'b0,
    PHASE_SECOND = 1'b1
  } byte_phase_t;

  localparam logic SEL_ENC_ONE = 1'b0;
  localparam logic SEL_ENC_TWO = 1'b1;

  function automatic logic signed [7:0] count_step(
    input logic signed [7:0] cnt,
    input logic              a,
    input logic              b,
    input logic              old_a,
    input logic              old_b,
    input logic              four_x
  );
    logic signed [7:0] res;
    res = cnt;
    if (a != old_a) begin
      res = (a == b) ? res + 8'sd1 : res - 8'sd1;
    end
    if (four_x && (b != old_b)) begin
      res = (a != b) ? res + 8'sd1 : res - 8'sd1;
    end
    return res;
  endfunction

endpackage

### hw/rtl/dual_quadrature_counter_readout.sv
// top level of the dual quadrature counter readout
// One pin sample is accepted every clock cycle while the read queue is not full; edges are counted
// in the cycle of acceptance and a read snapshots the counts at once. Each read leaves two output
// bytes (encoder 1, then encoder 2 with tlast) that the output register sends one after the other,
// each held until out_tready; new reads queue up meanwhile. A four-entry read queue sits between
// counting and output; in_tready drops only while it is full, so sampling continues while results wait.
module dual_quadrature_counter_readout (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,     // mode_four_x
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // enc1_phase_a, enc1_phase_b, enc2_phase_a, enc2_phase_b, zero pad
  input  logic       in_tuser,      // req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // delta_value
  output logic       out_tuser,     // encoder_sel
  output logic       out_tlast      // last_byte
);

  dqcr_pkg::queue_status_t q_status;
  dqcr_pkg::rec_t          push_rec, head_rec;
  logic                    push, pop;

  dqcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_levels (in_tdata[3:0]),
    .q_status  (q_status),
    .in_ready  (in_tready),
    .push      (push),
    .push_rec  (push_rec)
  );

  dqcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_status (q_status)
  );

  dqcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .q_status  (q_status),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_sel   (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

### hw/rtl/dqcr_front.sv
// front end: accepts pin samples, counts edges and snapshots the counts on a read
module dqcr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_req,
  input  logic [3:0]            in_levels,
  input  dqcr_pkg::queue_status_t q_status,
  output logic                  in_ready,
  output logic                  push,
  output dqcr_pkg::rec_t        push_rec
);

  logic                mode_four_x_r;
  logic [3:0]          prev_levels_r;
  logic signed [7:0]   live_one_r, live_two_r;
  logic signed [7:0]   held_one_r, held_two_r;
  logic signed [7:0]   live_one_nxt, live_two_nxt;
  logic                accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_req;

  assign push_rec.held_one = held_one_r;
  assign push_rec.held_two = held_two_r;

  always_comb begin
    live_one_nxt = dqcr_pkg::count_step(live_one_r, in_levels[0], in_levels[1],
                                        prev_levels_r[0], prev_levels_r[1], mode_four_x_r);
    live_two_nxt = dqcr_pkg::count_step(live_two_r, in_levels[2], in_levels[3],
                                        prev_levels_r[2], prev_levels_r[3], mode_four_x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_four_x_r <= 1'b0;
      prev_levels_r <= 4'hF;
      live_one_r    <= '0;
      live_two_r    <= '0;
      held_one_r    <= '0;
      held_two_r    <= '0;
    end else begin
      if (cfg_we) begin
        mode_four_x_r <= cfg_wdata;
      end
      if (accept) begin
        prev_levels_r <= in_levels;
        if (in_req) begin
          held_one_r <= live_one_nxt;
          held_two_r <= live_two_nxt;
          live_one_r <= '0;
          live_two_r <= '0;
        end else begin
          live_one_r <= live_one_nxt;
          live_two_r <= live_two_nxt;
        end
      end
    end
  end

endmodule

### hw/rtl/dqcr_queue.sv
// short queue of pending read transactions between front and back
module dqcr_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  dqcr_pkg::rec_t          push_rec,
  input  logic                    pop,
  output dqcr_pkg::rec_t          head_rec,
  output dqcr_pkg::queue_status_t q_status
);

  dqcr_pkg::rec_t                   mem_r [dqcr_pkg::QUEUE_DEPTH];
  logic [dqcr_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [dqcr_pkg::QCNT_W-1:0]      count_r;

  function automatic logic [dqcr_pkg::QPTR_W-1:0] ptr_inc(
    input logic [dqcr_pkg::QPTR_W-1:0] p
  );
    return (p == dqcr_pkg::QPTR_W'(dqcr_pkg::QUEUE_DEPTH - 1)) ?
           '0 : p + dqcr_pkg::QPTR_W'(1);
  endfunction

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == dqcr_pkg::QCNT_W'(dqcr_pkg::QUEUE_DEPTH));
  assign head_rec       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + dqcr_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - dqcr_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dqcr_pkg::QCNT_W'(dqcr_pkg::QUEUE_DEPTH)) else $error("queue count overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_status.empty) else $error("queue empty after push");

endmodule

### hw/rtl/dqcr_back.sv
// back end: turns each queued read into two output bytes through an output register
module dqcr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dqcr_pkg::rec_t          head_rec,
  input  dqcr_pkg::queue_status_t q_status,
  output logic                    pop,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_data,
  output logic                    out_sel,
  output logic                    out_last
);

  dqcr_pkg::byte_phase_t phase_r, phase_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r, out_data_nxt;
  logic                  out_sel_r, out_sel_nxt;
  logic                  load;

  assign load      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_sel   = out_sel_r;
  assign out_last  = out_sel_r;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_sel_nxt   = out_sel_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      unique case (phase_r)
        dqcr_pkg::PHASE_FIRST: begin
          if (!q_status.empty) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = head_rec.held_one;
            out_sel_nxt   = dqcr_pkg::SEL_ENC_ONE;
            phase_nxt     = dqcr_pkg::PHASE_SECOND;
          end
        end
        dqcr_pkg::PHASE_SECOND: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = head_rec.held_two;
          out_sel_nxt   = dqcr_pkg::SEL_ENC_TWO;
          phase_nxt     = dqcr_pkg::PHASE_FIRST;
          pop           = 1'b1;
        end
        default: phase_nxt = dqcr_pkg::PHASE_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dqcr_pkg::PHASE_FIRST;
      out_valid_r <= 1'b0;
      out_sel_r   <= dqcr_pkg::SEL_ENC_ONE;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      out_sel_r   <= out_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_second_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dqcr_pkg::PHASE_SECOND) |-> !q_status.empty)
    else $error("second byte pending without queued read");

  a_first_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sel_r == dqcr_pkg::SEL_ENC_ONE) |-> (phase_r == dqcr_pkg::PHASE_SECOND))
    else $error("first byte shown without second pending");

  a_pop_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && out_sel_r == dqcr_pkg::SEL_ENC_TWO))
    else $error("pop without second byte loaded");

endmodule
